@@ rtl/core/utf8_to_utf16le_transcoder_macros.svh @@
// Assertion macros shared by the transcoder's checker.
// No dependencies; include by bare file name.
`ifndef UTF8_TO_UTF16LE_TRANSCODER_MACROS_SVH
`define UTF8_TO_UTF16LE_TRANSCODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define U8U16_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("transcoder assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define U8U16_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("transcoder assertion failed");

`endif

@@ rtl/core/u8u16_pkg.sv @@
// Shared types and constants of the UTF-8 to UTF-16LE transcoder.
// No dependencies.
package u8u16_pkg;

	// Kind of a decoded item handed from the front part to the back part.
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_UNIT = 2'd0;	// code point below 0x10000
	localparam kind_t KIND_PAIR = 2'd1;	// code point that needs surrogates
	localparam kind_t KIND_TERM = 2'd2;	// terminating zero

	localparam int CP_W = 21;
	localparam int UNIT_W = 16;

	localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;
	localparam logic [UNIT_W-1:0] HIGH_SURR_BASE = 16'hD800;
	localparam logic [UNIT_W-1:0] LOW_SURR_BASE = 16'hDC00;
	localparam logic [9:0] SURR_MASK = 10'h3FF;

	typedef struct packed {
		kind_t kind;
		logic [CP_W-1:0] cp;
	} cp_entry_t;

endpackage

@@ rtl/core/u8u16_front.sv @@
// Front part: takes UTF-8 bytes, gathers code points and classifies them.
// Depends on u8u16_pkg.
module u8u16_front import u8u16_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic byte_take,
	input  logic [7:0] text_byte,
	input  logic start_of_text,
	output logic entry_wr,
	output cp_entry_t entry
);

	logic [1:0] rem_q;
	logic [CP_W-1:0] acc_q;
	logic ended_q;

	logic [1:0] rem_eff, rem_d;
	logic [CP_W-1:0] acc_eff, acc_d, fin_cp;
	logic ended_eff, ended_d;
	logic fin, term;

	always_comb begin
		rem_eff = start_of_text ? 2'd0 : rem_q;
		acc_eff = start_of_text ? '0 : acc_q;
		ended_eff = start_of_text ? 1'b0 : ended_q;
		rem_d = rem_eff;
		acc_d = acc_eff;
		ended_d = ended_eff;
		fin = 1'b0;
		term = 1'b0;
		fin_cp = '0;
		if (!ended_eff) begin
			if (rem_eff != 2'd0) begin
				acc_d = {acc_eff[CP_W-7:0], text_byte[5:0]};
				rem_d = rem_eff - 2'd1;
				fin = (rem_d == 2'd0);
				fin_cp = acc_d;
			end else begin
				case (text_byte) inside
					[8'h00:8'h7F]: begin
						fin = 1'b1;
						fin_cp = {{(CP_W-8){1'b0}}, text_byte};
					end
					[8'hC0:8'hDF]: begin
						acc_d = {{(CP_W-5){1'b0}}, text_byte[4:0]};
						rem_d = 2'd1;
					end
					[8'hE0:8'hEF]: begin
						acc_d = {{(CP_W-4){1'b0}}, text_byte[3:0]};
						rem_d = 2'd2;
					end
					[8'hF0:8'hF7]: begin
						acc_d = {{(CP_W-3){1'b0}}, text_byte[2:0]};
						rem_d = 2'd3;
					end
					default: begin
						term = 1'b1;
					end
				endcase
			end
			// A code point of zero ends the text just as a bad lead byte does.
			if (fin && fin_cp == '0) begin
				term = 1'b1;
			end
			if (term) begin
				ended_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 2'd0;
			acc_q <= '0;
			ended_q <= 1'b0;
		end else if (byte_take) begin
			rem_q <= rem_d;
			acc_q <= acc_d;
			ended_q <= ended_d;
		end
	end

	assign entry_wr = byte_take && (fin || term);

	always_comb begin
		entry.cp = fin_cp;
		if (term) begin
			entry.kind = KIND_TERM;
		end else if (fin_cp >= SUPP_BASE) begin
			entry.kind = KIND_PAIR;
		end else begin
			entry.kind = KIND_UNIT;
		end
	end

endmodule

@@ rtl/core/u8u16_fifo.sv @@
// Short queue of classified code points between the front and back parts.
// Depends on u8u16_pkg.
module u8u16_fifo import u8u16_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  cp_entry_t wr_entry,
	input  logic rd,
	output cp_entry_t rd_entry,
	output logic not_empty,
	output logic full
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cp_entry_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_wr, do_rd;

	assign full = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && not_empty;
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/u8u16_back.sv @@
// Back part: turns queued code points into UTF-16 units in an output register.
// Depends on u8u16_pkg.
module u8u16_back import u8u16_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic head_valid,
	input  cp_entry_t head,
	output logic head_pop,
	input  logic pop,
	output logic empty,
	output logic [15:0] utf16_unit,
	output logic end_of_text,
	output logic last_of_run
);

	logic out_valid_q;
	logic [UNIT_W-1:0] unit_q;
	logic eot_q, last_q;
	logic half_q;

	logic load;
	logic [CP_W-1:0] offs;
	logic [UNIT_W-1:0] high_unit, low_unit, unit_d;
	logic eot_d, last_d, high_d;

	assign offs = head.cp - SUPP_BASE;
	assign high_unit = UNIT_W'(offs[CP_W-1:10]) + HIGH_SURR_BASE;
	assign low_unit = {6'd0, head.cp[9:0] & SURR_MASK} + LOW_SURR_BASE;

	assign load = head_valid && (!out_valid_q || pop);

	always_comb begin
		unit_d = head.cp[UNIT_W-1:0];
		eot_d = 1'b0;
		last_d = 1'b1;
		high_d = 1'b0;
		case (head.kind)
			KIND_PAIR: begin
				if (!half_q) begin
					unit_d = high_unit;
					last_d = 1'b0;
					high_d = 1'b1;
				end else begin
					unit_d = low_unit;
				end
			end
			KIND_TERM: begin
				unit_d = '0;
				eot_d = 1'b1;
			end
			default: begin
				unit_d = head.cp[UNIT_W-1:0];
			end
		endcase
	end

	// The queue entry stays at the head until its last unit is loaded.
	assign head_pop = load && !high_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			half_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				half_q <= high_d;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			unit_q <= unit_d;
			eot_q <= eot_d;
			last_q <= last_d;
		end
	end

	assign empty = !out_valid_q;
	assign utf16_unit = unit_q;
	assign end_of_text = eot_q;
	assign last_of_run = last_q;

endmodule

@@ rtl/core/utf8_to_utf16le_transcoder.sv @@
// UTF-8 to UTF-16LE transcoder, top level. Bytes enter through a queue-like
// push/full port and UTF-16 code units leave through an empty/pop port. One
// byte is taken per cycle while full is low. A byte that completes a code point
// below 0x10000 yields one unit, one at or above it yields a high and then a low
// surrogate, and a NUL, an invalid lead byte or a decoded zero yields a
// terminating zero unit with end_of_text set, after which bytes are dropped
// until start_of_text. A unit passes through the queue and then the output
// register before it appears on the result ports. The sustained rate is one
// byte per cycle as long as results are popped every cycle; it is set by the
// back part, which loads one unit per cycle into the output register while that
// register is empty or being popped. Since a surrogate pair needs a four-byte
// sequence, units never outrun the bytes, so full is raised only when results
// are not popped and the FIFO_DEPTH-entry queue between front and back fills;
// it stays up until the back part catches up.
module utf8_to_utf16le_transcoder import u8u16_pkg::*; #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic [7:0] text_byte,
	input  logic start_of_text,
	output logic empty,
	input  logic pop,
	output logic [15:0] utf16_unit,
	output logic end_of_text,
	output logic last_of_run
);

	logic byte_take;
	logic entry_wr;
	cp_entry_t entry, head;
	logic head_valid, head_pop, q_full;

	// A byte transfer happens only when the queue can take whatever it yields.
	assign full = q_full;
	assign byte_take = push && !q_full;

	u8u16_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.byte_take(byte_take),
		.text_byte(text_byte),
		.start_of_text(start_of_text),
		.entry_wr(entry_wr),
		.entry(entry)
	);

	u8u16_fifo #(
		.DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr(entry_wr),
		.wr_entry(entry),
		.rd(head_pop),
		.rd_entry(head),
		.not_empty(head_valid),
		.full(q_full)
	);

	u8u16_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head(head),
		.head_pop(head_pop),
		.pop(pop),
		.empty(empty),
		.utf16_unit(utf16_unit),
		.end_of_text(end_of_text),
		.last_of_run(last_of_run)
	);

endmodule

@@ rtl/core/u8u16_checker.sv @@
// Port-level checks of the transcoder, attached to the top level by bind.
// Depends on utf8_to_utf16le_transcoder_macros.svh.
`include "utf8_to_utf16le_transcoder_macros.svh"

module u8u16_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic full,
	input  logic [7:0] text_byte,
	input  logic start_of_text,
	input  logic empty,
	input  logic pop,
	input  logic [15:0] utf16_unit,
	input  logic end_of_text,
	input  logic last_of_run
);

	// A unit that is not the last of its byte can only be a high surrogate. For code
	// points above the Unicode range it runs past 0xDBFF, but never beyond 0xDFFF.
	`U8U16_ASSERT_NOW(a_high_form, clk, arst_n, !empty && !last_of_run, utf16_unit[15:11] == 5'b11011)

	// The terminator is a zero unit and ends its run; other units are never zero.
	`U8U16_ASSERT_NOW(a_term_form, clk, arst_n, !empty, end_of_text == (utf16_unit == 16'd0) && (!end_of_text || last_of_run))

	// Taking a high surrogate brings its low surrogate on the next cycle.
	`U8U16_ASSERT_NEXT(a_pair_follow, clk, arst_n, !empty && pop && !last_of_run, !empty && utf16_unit[15:10] == 6'b110111)

	// A waiting result holds until its transfer.
	`U8U16_ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(utf16_unit))

endmodule

bind utf8_to_utf16le_transcoder u8u16_checker u_checker (.*);

@@ dv/tb_utf8_to_utf16le_transcoder.sv @@
// Self-checking testbench for utf8_to_utf16le_transcoder: a byte driver and a unit
// monitor around the block, checked against a decoder model kept in this file.
// Depends on the RTL package u8u16_pkg and the transcoder top level.
`timescale 1ns / 100ps

module tb_utf8_to_utf16le_transcoder;
	import u8u16_pkg::*;

	// Cycles without any transfer on either side before the run is abandoned.
	// The worst legal gap is a long run of sender idles, which stays far below this.
	localparam int STALL_LIMIT = 3000;
	// Cycles left for stray units after the last expected one has arrived.
	localparam int TAIL_CYCLES = 20;
	localparam int RANDOM_BYTES = 1550;
	localparam int NUM_PHASES = 4;
	localparam int MAX_PRINTED = 40;

	// One byte waiting to be offered to the block. A byte marked wait_drain is held
	// back until every unit predicted so far has been transferred out.
	typedef struct {
		logic [7:0] b;
		logic sot;
		bit wait_drain;
		int phase;
	} byte_item_t;

	// One UTF-16 unit as the block should present it.
	typedef struct {
		logic [UNIT_W-1:0] unit;
		logic eot;
		logic last;
	} unit_t;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic [7:0] text_byte;
	logic start_of_text;
	logic empty;
	logic pop;
	logic [UNIT_W-1:0] utf16_unit;
	logic end_of_text;
	logic last_of_run;

	utf8_to_utf16le_transcoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.text_byte(text_byte),
		.start_of_text(start_of_text),
		.empty(empty),
		.pop(pop),
		.utf16_unit(utf16_unit),
		.end_of_text(end_of_text),
		.last_of_run(last_of_run)
	);

	// Idle percentages per phase: no idling, sender idle, receiver stalling, both.
	int unsigned send_idle_pct [NUM_PHASES] = '{0, 47, 0, 19};
	int unsigned recv_stall_pct [NUM_PHASES] = '{0, 0, 47, 19};

	byte_item_t bytes_to_send [$];
	unit_t units_due [$];

	// Decoder state, mirroring what the block keeps between bytes.
	logic [1:0] cont_left;
	logic [CP_W-1:0] cp_acc;
	logic text_done;

	int phase;
	bit byte_taken;
	int idle_cycles;
	int mismatches;
	int bytes_sent;
	int units_checked;
	int pairs_seen;
	int terminators_seen;
	int texts_started;
	int live_bytes;
	int gen_phase;
	bit gen_drain;

	// ------------------------------------------------------------------
	// Decoder model
	// ------------------------------------------------------------------

	// Turns a finished code point into its units. Zero ends the text; anything at or
	// above the supplementary base splits into a surrogate pair, and the high half
	// runs past 0xDBFF when the code point lies beyond the Unicode range.
	function automatic void finish_code_point(input logic [CP_W-1:0] cp);
		logic [CP_W-1:0] offset;
		unit_t u;
		if (cp == '0) begin
			text_done = 1'b1;
			u.unit = '0;
			u.eot = 1'b1;
			u.last = 1'b1;
			units_due.push_back(u);
		end else if (cp < SUPP_BASE) begin
			u.unit = cp[UNIT_W-1:0];
			u.eot = 1'b0;
			u.last = 1'b1;
			units_due.push_back(u);
		end else begin
			offset = cp - SUPP_BASE;
			u.unit = UNIT_W'(offset >> 10) + HIGH_SURR_BASE;
			u.eot = 1'b0;
			u.last = 1'b0;
			units_due.push_back(u);
			u.unit = UNIT_W'(cp[9:0] & SURR_MASK) + LOW_SURR_BASE;
			u.last = 1'b1;
			units_due.push_back(u);
		end
	endfunction

	// Advances the decoder by one accepted byte and queues the units it yields.
	function automatic void decode_byte(input logic [7:0] b, input logic sot);
		unit_t u;
		if (sot) begin
			cont_left = '0;
			cp_acc = '0;
			text_done = 1'b0;
		end
		if (text_done)
			return;
		if (cont_left != 2'd0) begin
			// Continuations are taken on trust: only the low six bits count.
			cp_acc = {cp_acc[CP_W-7:0], b[5:0]};
			cont_left = cont_left - 2'd1;
			if (cont_left == 2'd0)
				finish_code_point(cp_acc);
		end else if (!b[7]) begin
			finish_code_point(CP_W'(b));
		end else if (b[7:5] == 3'b110) begin
			cp_acc = CP_W'(b[4:0]);
			cont_left = 2'd1;
		end else if (b[7:4] == 4'b1110) begin
			cp_acc = CP_W'(b[3:0]);
			cont_left = 2'd2;
		end else if (b[7:3] == 5'b11110) begin
			cp_acc = CP_W'(b[2:0]);
			cont_left = 2'd3;
		end else begin
			// A stray continuation or a lead above 0xF7 ends the text.
			text_done = 1'b1;
			u.unit = '0;
			u.eot = 1'b1;
			u.last = 1'b1;
			units_due.push_back(u);
		end
	endfunction

	// ------------------------------------------------------------------
	// Stimulus building
	// ------------------------------------------------------------------

	// Bytes that the block will drop after a terminator are passed with live = 0 so
	// they do not count toward the random byte budget.
	function automatic void add_byte(input logic [7:0] b, input logic sot, input bit live);
		byte_item_t it;
		it.b = b;
		it.sot = sot;
		it.wait_drain = gen_drain;
		it.phase = gen_phase;
		gen_drain = 1'b0;
		bytes_to_send.push_back(it);
		if (live)
			live_bytes++;
		if (sot)
			texts_started++;
	endfunction

	// Continuation byte carrying six payload bits. Now and then its marker bits are
	// garbled, which the block must not notice.
	function automatic logic [7:0] cont_byte(input logic [5:0] bits);
		logic [1:0] mark;
		mark = 2'b10;
		if ($urandom_range(0, 15) == 0)
			mark = 2'($urandom_range(0, 3));
		return {mark, bits};
	endfunction

	// Encodes cp with the given sequence length, overlong forms included.
	function automatic void add_char(input logic [CP_W-1:0] cp, input int len, input logic sot);
		case (len)
			1: begin
				add_byte({1'b0, cp[6:0]}, sot, 1'b1);
			end
			2: begin
				add_byte({3'b110, cp[10:6]}, sot, 1'b1);
				add_byte(cont_byte(cp[5:0]), 1'b0, 1'b1);
			end
			3: begin
				add_byte({4'b1110, cp[15:12]}, sot, 1'b1);
				add_byte(cont_byte(cp[11:6]), 1'b0, 1'b1);
				add_byte(cont_byte(cp[5:0]), 1'b0, 1'b1);
			end
			default: begin
				add_byte({5'b11110, cp[20:18]}, sot, 1'b1);
				add_byte(cont_byte(cp[17:12]), 1'b0, 1'b1);
				add_byte(cont_byte(cp[11:6]), 1'b0, 1'b1);
				add_byte(cont_byte(cp[5:0]), 1'b0, 1'b1);
			end
		endcase
	endfunction

	// One random character, mostly well formed, sometimes a raw noise byte that may
	// also restart the text.
	function automatic void add_random_char(input logic sot);
		int pick;
		logic [CP_W-1:0] cp;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			add_char(CP_W'($urandom_range(1, 8'h7F)), 1, sot);
		end else if (pick < 60) begin
			add_char(CP_W'($urandom_range(0, 11'h7FF)), 2, sot);
		end else if (pick < 80) begin
			add_char(CP_W'($urandom_range(0, 16'hFFFF)), 3, sot);
		end else if (pick < 95) begin
			if ($urandom_range(0, 3) != 0)
				cp = CP_W'($urandom_range(21'h10000, 21'h10FFFF));
			else
				cp = CP_W'($urandom_range(0, 21'h1FFFFF));
			add_char(cp, 4, sot);
		end else begin
			add_byte(8'($urandom_range(0, 255)), sot | ($urandom_range(0, 7) == 0), 1'b1);
		end
	endfunction

	// One random text: a string of characters, then either a terminator and up to three
	// bytes that the block should drop, or a sequence cut short, or no ending at all.
	function automatic void add_random_text();
		int n_chars;
		int ending;
		n_chars = $urandom_range(1, 30);
		for (int i = 0; i < n_chars; i++)
			add_random_char(i == 0);
		ending = $urandom_range(0, 99);
		if (ending < 40) begin
			add_byte(8'h00, 1'b0, 1'b1);
		end else if (ending < 55) begin
			if ($urandom_range(0, 1) != 0)
				add_byte(8'($urandom_range(8'h80, 8'hBF)), 1'b0, 1'b1);
			else
				add_byte(8'($urandom_range(8'hF8, 8'hFF)), 1'b0, 1'b1);
		end else if (ending < 65) begin
			// Overlong encoding of zero.
			add_char('0, $urandom_range(2, 4), 1'b0);
		end else if (ending < 75) begin
			// A sequence cut short; the next text's start flag must discard it.
			add_byte(8'($urandom_range(8'hC0, 8'hF7)), 1'b0, 1'b1);
			if ($urandom_range(0, 1) != 0)
				add_byte(cont_byte(6'($urandom_range(0, 63))), 1'b0, 1'b1);
			return;
		end else begin
			return;
		end
		repeat ($urandom_range(0, 3))
			add_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
	endfunction

	// ------------------------------------------------------------------
	// Clock and reset
	// ------------------------------------------------------------------

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// ------------------------------------------------------------------
	// Byte driver: offers the queued bytes at the falling edge, holding a byte until
	// its transfer, idling at random by phase, and holding back a byte marked
	// wait_drain until all predicted units have gone out.
	// ------------------------------------------------------------------

	always @(negedge clk) begin
		byte_item_t nxt;
		if (!arst_n) begin
			push <= 1'b0;
		end else if (push && !byte_taken) begin
			// The offered byte has not been transferred yet; keep it on the ports.
		end else if (bytes_to_send.size() != 0
				&& !(bytes_to_send[0].wait_drain && units_due.size() != 0)
				&& $urandom_range(0, 99) >= send_idle_pct[bytes_to_send[0].phase]) begin
			nxt = bytes_to_send.pop_front();
			push <= 1'b1;
			text_byte <= nxt.b;
			start_of_text <= nxt.sot;
			phase <= nxt.phase;
		end else begin
			push <= 1'b0;
		end
	end

	// Unit receiver: pops with a stall rate taken from the current phase.
	always @(negedge clk) begin
		if (!arst_n)
			pop <= 1'b0;
		else
			pop <= ($urandom_range(0, 99) >= recv_stall_pct[phase]);
	end

	// ------------------------------------------------------------------
	// Monitor, predictor and watchdog, all at the rising edge. Outputs are checked
	// before the byte of the same edge is decoded, so that a unit can never be
	// matched against a prediction made in the same cycle.
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string msg);
		if (mismatches < MAX_PRINTED)
			$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	always @(posedge clk) begin
		unit_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (units_due.size() == 0) begin
					report_mismatch($sformatf("unit %h transferred with none expected",
						utf16_unit));
				end else begin
					want = units_due.pop_front();
					if (utf16_unit !== want.unit)
						report_mismatch($sformatf("utf16_unit got %h, expected %h",
							utf16_unit, want.unit));
					if (end_of_text !== want.eot)
						report_mismatch($sformatf("end_of_text got %b, expected %b",
							end_of_text, want.eot));
					if (last_of_run !== want.last)
						report_mismatch($sformatf("last_of_run got %b, expected %b",
							last_of_run, want.last));
					units_checked++;
					if (!want.last)
						pairs_seen++;
					if (want.eot)
						terminators_seen++;
				end
			end

			if (push && !full) begin
				decode_byte(text_byte, start_of_text);
				bytes_sent++;
			end
			byte_taken <= push && !full;

			if ((push && !full) || (pop && !empty))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Timeout: no transfer for %0d cycles, %0d units outstanding",
					STALL_LIMIT, units_due.size());
				$display("Verification failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------

	initial begin
		push = 1'b0;
		pop = 1'b0;
		text_byte = '0;
		start_of_text = 1'b0;
		byte_taken = 1'b0;
		phase = 0;
		idle_cycles = 0;
		mismatches = 0;
		bytes_sent = 0;
		units_checked = 0;
		pairs_seen = 0;
		terminators_seen = 0;
		texts_started = 0;
		live_bytes = 0;
		cont_left = '0;
		cp_acc = '0;
		text_done = 1'b0;

		// Directed part, without idling. Largest one-byte character first.
		gen_phase = 0;
		gen_drain = 1'b1;
		add_byte(8'h7F, 1'b1, 1'b1);
		// A NUL is accepted as a continuation: C2 00 decodes to U+0080.
		add_byte(8'hC2, 1'b0, 1'b1);
		add_byte(8'h00, 1'b0, 1'b1);
		// Largest two- and three-byte characters.
		add_byte(8'hDF, 1'b0, 1'b1);
		add_byte(8'hBF, 1'b0, 1'b1);
		add_byte(8'hEF, 1'b0, 1'b1);
		add_byte(8'hBF, 1'b0, 1'b1);
		add_byte(8'hBF, 1'b0, 1'b1);
		// U+10FFFF, the top of Unicode, as a surrogate pair.
		add_byte(8'hF4, 1'b0, 1'b1);
		add_byte(8'h8F, 1'b0, 1'b1);
		add_byte(8'hBF, 1'b0, 1'b1);
		add_byte(8'hBF, 1'b0, 1'b1);
		// Largest four-byte form with all-ones continuations; the high unit runs past 0xDBFF.
		add_byte(8'hF7, 1'b0, 1'b1);
		add_byte(8'hFF, 1'b0, 1'b1);
		add_byte(8'hFF, 1'b0, 1'b1);
		add_byte(8'hFF, 1'b0, 1'b1);
		// An open sequence dropped by a new text, which then sends U+10000.
		add_byte(8'hE0, 1'b0, 1'b1);
		add_byte(8'hF0, 1'b1, 1'b1);
		add_byte(8'h90, 1'b0, 1'b1);
		add_byte(8'h80, 1'b0, 1'b1);
		add_byte(8'h80, 1'b0, 1'b1);
		// Overlong zero ends the text; the byte after it must be dropped.
		add_byte(8'hC0, 1'b0, 1'b1);
		add_byte(8'h80, 1'b0, 1'b1);
		add_byte(8'h41, 1'b0, 1'b0);
		// Invalid leads at both ends of the invalid ranges, and a plain NUL.
		add_byte(8'hFF, 1'b1, 1'b1);
		add_byte(8'h80, 1'b1, 1'b1);
		add_byte(8'h00, 1'b1, 1'b1);

		// Random part, in four idling phases. The first byte of each phase waits
		// until all earlier units are out, so every phase starts from a quiet block.
		for (int p = 0; p < NUM_PHASES; p++) begin
			gen_phase = p;
			gen_drain = 1'b1;
			while (live_bytes < 27 + RANDOM_BYTES * (p + 1) / NUM_PHASES)
				add_random_text();
		end

		// Wait for every byte to be transferred and every predicted unit to arrive,
		// then give the block time to show any unit that should not be there.
		do
			@(negedge clk);
		while (bytes_to_send.size() != 0 || push || units_due.size() != 0);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Sent %0d bytes in %0d texts through four idling phases.",
			bytes_sent, texts_started);
		$display("Checked %0d units: %0d surrogate pairs, %0d terminators, %0d mismatches.",
			units_checked, pairs_seen, terminators_seen, mismatches);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
